@@ design/pftc_pkg.sv @@
// Package with types and constants shared by the per-flow traffic counter.
`timescale 1ns / 1ps
`default_nettype none
package pftc_pkg;
    localparam int FLOW_ENTRIES      = 64;
    localparam int PACKET_COUNT_BITS = 32;
    localparam int BYTE_COUNT_BITS   = 48;
    localparam int IDX_W             = $clog2(FLOW_ENTRIES);
    localparam int KEY_W             = 48;
    localparam int HDR_W             = 104;
    localparam int QUEUE_DEPTH       = 4;
    localparam int Q_IDX_W           = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    localparam logic REG_ENABLED     = 1'b0;
    localparam logic REG_KEY_BY_PEER = 1'b1;

    typedef enum logic [2:0] {
        ST_COUNTED    = 3'd0,
        ST_NEW_FLOW   = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_DISABLED   = 3'd4,
        ST_DUMP_ENTRY = 3'd5,
        ST_DUMP_EMPTY = 3'd6
    } t_status;

    typedef struct packed {
        logic        command;
        logic        direction;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [19:0] buffer_size;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  flow_protocol;
        logic [31:0] flow_src_addr;
        logic [15:0] flow_src_port;
        logic [31:0] flow_dst_addr;
        logic [15:0] flow_dst_port;
        logic [31:0] rx_packets;
        logic [47:0] rx_bytes;
        logic [31:0] tx_packets;
        logic [47:0] tx_bytes;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_COUNT,
        OP_DUMP,
        OP_REPORT
    } t_op;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        t_op              op;
        t_status          status;
        logic             direction;
        logic [KEY_W-1:0] key;
        logic [HDR_W-1:0] header;
        logic [19:0]      buffer_size;
    } t_work;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_READ,
        BK_UPDATE,
        BK_OUTPUT
    } t_bk_state;
endpackage
`default_nettype wire

@@ design/pftc_front.sv @@
// Front part: registers configuration, classifies items and builds flow keys.
`timescale 1ns / 1ps
`default_nettype none
module pftc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  pftc_pkg::t_in_item  i_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire                 i_cfg_data,
    output logic                o_wk_valid,
    output pftc_pkg::t_work     o_wk_data,
    input  wire                 i_wk_full
);
    import pftc_pkg::*;

    logic r_enabled, r_key_by_peer;
    logic use_src;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_wk_full;
    assign o_wk_valid  = i_valid && !i_wk_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_key_by_peer <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ENABLED) begin
                r_enabled <= i_cfg_data;
            end
            if (i_cfg_index == REG_KEY_BY_PEER) begin
                r_key_by_peer <= i_cfg_data;
            end
        end
    end

    assign use_src = i_data.direction || r_key_by_peer;

    always_comb begin
        o_wk_data.direction   = i_data.direction;
        o_wk_data.buffer_size = i_data.buffer_size;
        o_wk_data.header      = {i_data.protocol, i_data.src_addr, i_data.src_port,
                                 i_data.dst_addr, i_data.dst_port};
        o_wk_data.key         = use_src ? {i_data.src_addr, i_data.src_port}
                                        : {i_data.dst_addr, i_data.dst_port};
        o_wk_data.op          = OP_REPORT;
        o_wk_data.status      = ST_COUNTED;
        if (i_data.command == CMD_DUMP) begin
            o_wk_data.op = OP_DUMP;
        end else if (!r_enabled) begin
            o_wk_data.status = ST_DISABLED;
        end else if (i_data.protocol != PROTO_TCP && i_data.protocol != PROTO_UDP) begin
            o_wk_data.status = ST_IGNORED;
        end else begin
            o_wk_data.op = OP_COUNT;
        end
    end
endmodule
`default_nettype wire

@@ design/pftc_queue.sv @@
// Short first-in first-out queue of classified work between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pftc_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pftc_pkg::t_work  i_data,
    output logic             o_full,
    output logic             o_valid,
    input  wire              i_pop,
    output pftc_pkg::t_work  o_data
);
    import pftc_pkg::*;

    t_work r_slot [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] r_wr, r_rd;
    logic [Q_IDX_W:0]   r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == (Q_IDX_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (Q_IDX_W+1)'(do_push) - (Q_IDX_W+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

@@ design/pftc_back.sv @@
// Back part: flow table search, counter update, dump and result register.
`timescale 1ns / 1ps
`default_nettype none
module pftc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wk_valid,
    input  pftc_pkg::t_work     i_wk_data,
    output logic                o_wk_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output pftc_pkg::t_out_item o_data
);
    import pftc_pkg::*;

    localparam logic [PACKET_COUNT_BITS-1:0] PKT_MAX = '1;
    localparam logic [BYTE_COUNT_BITS-1:0]   BYTE_MAX = '1;

    // Flow table memories: keys, headers and counters, one read and one write port each.
    logic [HDR_W-1:0]             r_hdr_mem [FLOW_ENTRIES];
    logic [PACKET_COUNT_BITS-1:0] r_rxp_mem [FLOW_ENTRIES];
    logic [BYTE_COUNT_BITS-1:0]   r_rxb_mem [FLOW_ENTRIES];
    logic [PACKET_COUNT_BITS-1:0] r_txp_mem [FLOW_ENTRIES];
    logic [BYTE_COUNT_BITS-1:0]   r_txb_mem [FLOW_ENTRIES];
    logic [KEY_W-1:0]             r_key_mem [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0]      r_valid;

    t_bk_state r_state, n_state;
    t_work     r_work;
    logic [IDX_W:0]   r_scan;
    logic [IDX_W-1:0] r_best;
    logic             r_found, r_free_found;
    logic [IDX_W-1:0] r_free;
    logic [KEY_W-1:0] r_key_rd;
    logic [IDX_W-1:0] r_sel;
    logic             r_new;

    logic [HDR_W-1:0]             r_hdr_rd;
    logic [PACKET_COUNT_BITS-1:0] r_rxp_rd, r_txp_rd;
    logic [BYTE_COUNT_BITS-1:0]   r_rxb_rd, r_txb_rd;
    t_out_item r_res;
    t_out_item r_out;
    logic      r_out_valid;

    logic [IDX_W-1:0] scan_idx, prev_idx;
    logic scan_done, out_free;
    logic key_load, take_work, prev_valid;
    logic [PACKET_COUNT_BITS-1:0] pkt_old, pkt_new;
    logic [BYTE_COUNT_BITS-1:0]   byte_old, byte_new;
    logic [BYTE_COUNT_BITS:0]     byte_sum;

    // The last entry is compared in the cycle before scan_done, so the selection
    // taken at scan_done sees the complete search.
    assign scan_idx  = r_scan[IDX_W-1:0];
    assign prev_idx  = scan_idx - 1'b1;
    assign scan_done = (r_scan == (IDX_W+1)'(FLOW_ENTRIES + 1));
    assign out_free  = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // Key memory read is registered; the compare uses the entry read in the previous cycle.
    always_ff @(posedge i_clk) begin
        r_key_rd <= r_key_mem[scan_idx];
        if (r_state == BK_UPDATE && r_new) begin
            r_key_mem[r_sel] <= r_work.key;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_wk_valid) begin
                    n_state = (i_wk_data.op == OP_REPORT) ? BK_OUTPUT : BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if (scan_done) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: n_state = BK_UPDATE;
            BK_UPDATE: n_state = BK_OUTPUT;
            BK_OUTPUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        take_work = (r_state == BK_IDLE) && i_wk_valid;
        key_load  = (r_state == BK_SEARCH);
        o_wk_pop  = take_work;
    end

    assign prev_valid = key_load && (r_scan != '0) && r_valid[prev_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_OUTPUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_UPDATE) begin
                if (r_work.op == OP_DUMP && r_found) begin
                    r_valid[r_sel] <= 1'b0;
                end else if (r_work.op == OP_COUNT && r_new) begin
                    r_valid[r_sel] <= 1'b1;
                end
            end
        end
    end

    // Sequential scan: one key per cycle, search for a hit and a free entry, or for a dump the smallest key.
    always_ff @(posedge i_clk) begin
        if (take_work) begin
            r_work       <= i_wk_data;
            r_scan       <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_free       <= '0;
            r_best       <= '0;
        end else if (key_load) begin
            if (!scan_done) begin
                r_scan <= r_scan + 1'b1;
            end
            if (r_scan != '0 && !scan_done) begin
                if (prev_valid) begin
                    if (r_work.op == OP_COUNT) begin
                        if (!r_found && r_key_rd == r_work.key) begin
                            r_found <= 1'b1;
                            r_best  <= prev_idx;
                        end
                    end else if (!r_found || r_key_rd < r_work.key) begin
                        r_found    <= 1'b1;
                        r_best     <= prev_idx;
                        r_work.key <= r_key_rd;
                    end
                end else if (!r_valid[prev_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= prev_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_SEARCH && scan_done) begin
            r_sel <= r_found ? r_best : r_free;
            r_new <= !r_found && r_free_found;
        end
    end

    // Header and counter memories: registered read, write on update.
    always_ff @(posedge i_clk) begin
        r_hdr_rd <= r_hdr_mem[r_sel];
        r_rxp_rd <= r_rxp_mem[r_sel];
        r_rxb_rd <= r_rxb_mem[r_sel];
        r_txp_rd <= r_txp_mem[r_sel];
        r_txb_rd <= r_txb_mem[r_sel];
        if (r_state == BK_UPDATE && r_work.op == OP_COUNT && (r_found || r_new)) begin
            if (r_new) begin
                r_hdr_mem[r_sel] <= r_work.header;
            end
            if (r_work.direction) begin
                r_txp_mem[r_sel] <= pkt_new;
                r_txb_mem[r_sel] <= byte_new;
                if (r_new) begin
                    r_rxp_mem[r_sel] <= '0;
                    r_rxb_mem[r_sel] <= '0;
                end
            end else begin
                r_rxp_mem[r_sel] <= pkt_new;
                r_rxb_mem[r_sel] <= byte_new;
                if (r_new) begin
                    r_txp_mem[r_sel] <= '0;
                    r_txb_mem[r_sel] <= '0;
                end
            end
        end
    end

    always_comb begin
        pkt_old  = r_work.direction ? r_txp_rd : r_rxp_rd;
        byte_old = r_work.direction ? r_txb_rd : r_rxb_rd;
        if (r_new) begin
            pkt_old  = '0;
            byte_old = '0;
        end
        pkt_new  = (pkt_old == PKT_MAX) ? PKT_MAX : pkt_old + 1'b1;
        byte_sum = {1'b0, byte_old} + (BYTE_COUNT_BITS+1)'(r_work.buffer_size);
        byte_new = byte_sum[BYTE_COUNT_BITS] ? BYTE_MAX : byte_sum[BYTE_COUNT_BITS-1:0];
    end

    // The result is built here and moves to the output register only once
    // the previous result has left.
    always_ff @(posedge i_clk) begin
        if (r_state == BK_UPDATE) begin
            r_res <= '0;
            if (r_work.op == OP_DUMP) begin
                if (r_found) begin
                    r_res.status     <= ST_DUMP_ENTRY;
                    {r_res.flow_protocol, r_res.flow_src_addr, r_res.flow_src_port,
                     r_res.flow_dst_addr, r_res.flow_dst_port} <= r_hdr_rd;
                    r_res.rx_packets <= r_rxp_rd;
                    r_res.rx_bytes   <= r_rxb_rd;
                    r_res.tx_packets <= r_txp_rd;
                    r_res.tx_bytes   <= r_txb_rd;
                end else begin
                    r_res.status <= ST_DUMP_EMPTY;
                end
            end else if (r_found) begin
                r_res.status <= ST_COUNTED;
            end else if (r_new) begin
                r_res.status <= ST_NEW_FLOW;
            end else begin
                r_res.status <= ST_TABLE_FULL;
            end
        end else if (r_state == BK_IDLE && take_work && i_wk_data.op == OP_REPORT) begin
            r_res        <= '0;
            r_res.status <= i_wk_data.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_OUTPUT && out_free) begin
            r_out <= r_res;
        end
    end
endmodule
`default_nettype wire

@@ design/per_flow_traffic_counter.sv @@
// Top level of the per-flow traffic counter.
//
//  Channel  | Direction | Handshake      | Payload
//  ---------+-----------+----------------+-------------------------------
//  in       | input     | valid / stall  | command, packet header, size
//  out      | output    | valid / stall  | status, flow header, counters
//  cfg      | input     | valid / ready  | register index, write data
//
// The time a packet or dump item spends in the back part is set by the scan
// of the key memory, one entry a cycle. Disabled and ignored items skip the
// scan. The front part accepts up to four items ahead into the work queue
// while the back part is busy or its output is stalled.
// Reset clears the valid bits of all entries at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module per_flow_traffic_counter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  pftc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output pftc_pkg::t_out_item o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire                 i_cfg_data
);
    import pftc_pkg::*;

    logic  wk_push, wk_full, wk_valid, wk_pop;
    t_work wk_in, wk_out;

    // The front part classifies each transfer and queues it.
    pftc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wk_valid  (wk_push),
        .o_wk_data   (wk_in),
        .i_wk_full   (wk_full)
    );

    pftc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wk_push),
        .i_data  (wk_in),
        .o_full  (wk_full),
        .o_valid (wk_valid),
        .i_pop   (wk_pop),
        .o_data  (wk_out)
    );

    // The back part owns the flow table and the result register.
    pftc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wk_valid (wk_valid),
        .i_wk_data  (wk_out),
        .o_wk_pop   (wk_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );
endmodule
`default_nettype wire

@@ design/pftc_checker.sv @@
// Port-level checker for the per-flow traffic counter and its bind.
`timescale 1ns / 1ps
`default_nettype none
module pftc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_valid,
    input wire                 i_stall,
    input pftc_pkg::t_out_item o_data,
    input wire                 o_cfg_ready
);
    import pftc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_DUMP_EMPTY)
        else $error("status code out of range");

    a_nondump_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_DUMP_ENTRY |->
            o_data.rx_packets == '0 && o_data.tx_packets == '0 && o_data.flow_protocol == '0)
        else $error("non-dump result carries flow data");

    a_dump_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_DUMP_ENTRY |->
            (o_data.rx_packets != '0 || o_data.tx_packets != '0))
        else $error("dumped flow has no packets");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");
endmodule

bind per_flow_traffic_counter pftc_checker u_pftc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data      (o_data),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire
